>>> hw/rtl/spar_pkg.sv
// ----------------------------------------------------------------------------
// spar_pkg
// shared types and constants of the still pose accelerometer recorder
// ----------------------------------------------------------------------------
package spar_pkg;

  localparam int MAX_WINDOW_DEF = 4096;
  localparam int AXES_DEF       = 3;

  localparam int SMP_W  = 16;
  localparam int VAR_W  = 40;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes
  localparam logic [2:0] REG_WAIT = 3'd0;
  localparam logic [2:0] REG_REF  = 3'd1;
  localparam logic [2:0] REG_WIN  = 3'd2;
  localparam logic [2:0] REG_STAB = 3'd3;
  localparam logic [2:0] REG_DEV  = 3'd4;

  localparam logic [11:0] WAIT_RST = 12'd100;
  localparam logic [11:0] REF_RST  = 12'd40;
  localparam logic [11:0] WIN_RST  = 12'd50;
  localparam logic [15:0] STAB_RST = 16'd983;
  localparam logic [23:0] DEV_RST  = 24'd393380;

  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  // shared unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } spar_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } spar_sts_t;

endpackage

>>> hw/rtl/spar_if.sv
// ----------------------------------------------------------------------------
// spar_if
// valid/ready channels for accelerometer samples and window results
// ----------------------------------------------------------------------------
interface spar_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface spar_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mean_x;
  logic signed [15:0] mean_y;
  logic signed [15:0] mean_z;
  logic [39:0]        window_variance;
  logic               accepted;

  modport source (output valid, mean_x, mean_y, mean_z, window_variance, accepted,
                  input ready);
  modport sink (input valid, mean_x, mean_y, mean_z, window_variance, accepted,
                output ready);
endinterface

>>> hw/rtl/spar_muldiv.sv
// ----------------------------------------------------------------------------
// spar_muldiv
// shared iterative unit: shift-add multiply and restoring divide, one bit a cycle
// ----------------------------------------------------------------------------
module spar_muldiv
  import spar_pkg::*;
#(
  parameter int W = 92
) (
  input  logic         clk,
  input  logic         rst_n,
  input  spar_cmd_t    cmd,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output spar_sts_t    sts,
  output logic [W-1:0] res
);

  localparam int NW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          op_r, op_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W:0]    acc_r, acc_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    rem_sh   = {acc_r[W-1:0], x_r[W-1]};
    if (!busy_r) begin
      if (cmd.start) begin
        busy_nxt = 1'b1;
        op_nxt   = cmd.op;
        x_nxt    = a;
        y_nxt    = b;
        acc_nxt  = '0;
        q_nxt    = '0;
        cnt_nxt  = NW'(W);
      end
    end else if (op_r == OP_MUL) begin
      if (y_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (y_r[0]) acc_nxt = acc_r + {1'b0, x_r};
        x_nxt = {x_r[W-2:0], 1'b0};
        y_nxt = {1'b0, y_r[W-1:1]};
      end
    end else begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (rem_sh >= {1'b0, y_r}) begin
          acc_nxt = rem_sh - {1'b0, y_r};
          q_nxt   = {q_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          q_nxt   = {q_r[W-2:0], 1'b0};
        end
        x_nxt   = {x_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = (op_r == OP_MUL) ? acc_r[W-1:0] : q_r;

endmodule

>>> hw/rtl/still_pose_accel_recorder.sv
// ----------------------------------------------------------------------------
// still_pose_accel_recorder
// windowed mean/variance stillness detector for a three-axis accelerometer
// ----------------------------------------------------------------------------
// Each sample is handled by a small sequencer around one shared shift-add
// multiplier / restoring divider that retires one bit per cycle; in_chan.ready
// is low while it works. A discarded sample is taken in the idle state. An
// ordinary sample holds the input through the accept, 3 squarings (each a
// start, one step per bit of the magnitude and a finish) and a window check.
// At a window end (and the end of the reference window) the unit also runs
// the variance products and a W-bit division (W = 66 + 2*clog2(MAX_WINDOW+1),
// 92 at the default), and at a record window end three more mean divisions,
// the squared distances and the acceptance products. A finished result sits
// in an output register, so the next sample is taken while it waits.
module still_pose_accel_recorder
  import spar_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int AXES       = AXES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  spar_in_if.sink           in_chan,
  spar_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int L  = $clog2(MAX_WINDOW + 1);
  localparam int CW = (L > 12) ? L : 12;
  localparam int SW = 17 + L;
  localparam int QW = 31 + L;
  localparam int W  = 66 + 2 * L;
  localparam int KW = (AXES > 1) ? $clog2(AXES) : 1;

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_REF  = 2'd1;
  localparam logic [1:0] PH_REC  = 2'd2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_NSQ  = 4'd3;
  localparam logic [3:0] S_SS   = 4'd4;
  localparam logic [3:0] S_N2   = 4'd5;
  localparam logic [3:0] S_VDIV = 4'd6;
  localparam logic [3:0] S_MDIV = 4'd7;
  localparam logic [3:0] S_DSQ  = 4'd8;
  localparam logic [3:0] S_ND2  = 4'd9;
  localparam logic [3:0] S_P1   = 4'd10;
  localparam logic [3:0] S_P2   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic [KW-1:0] K_LAST = KW'(AXES - 1);

  // configuration
  logic [11:0] wait_r, ref_r, win_r;
  logic [15:0] stab_r;
  logic [23:0] dev_r;

  logic [3:0]        st_r, st_nxt;
  logic              busy_wait_r, busy_wait_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic signed [SW-1:0] sum_r [AXES];
  logic signed [SW-1:0] sum_nxt [AXES];
  logic [QW-1:0]     sq_r [AXES];
  logic [QW-1:0]     sq_nxt [AXES];
  logic signed [15:0] last_r [AXES];
  logic signed [15:0] last_nxt [AXES];
  logic signed [15:0] mean_r [AXES];
  logic signed [15:0] mean_nxt [AXES];
  logic signed [15:0] smp_r [AXES];
  logic signed [15:0] smp_in [3];
  logic [VAR_W-1:0]  refvar_r, refvar_nxt;
  logic [VAR_W-1:0]  var_r, var_nxt;
  logic [W-1:0]      num_r, num_nxt;
  logic [W-1:0]      tmp_r, tmp_nxt;
  logic [W-1:0]      p1_r, p1_nxt;
  logic [35:0]       d2_r, d2_nxt;
  logic              ok_r, ok_nxt;
  logic              ov_r, ov_nxt;
  logic signed [15:0] om_r [3];
  logic signed [15:0] om_nxt [3];
  logic [VAR_W-1:0]  ovar_r, ovar_nxt;
  logic              oacc_r, oacc_nxt;

  spar_cmd_t    cmd;
  spar_sts_t    sts;
  logic [W-1:0] u_a, u_b, u_res;

  logic          in_fire, cfg_wr, op_state, unit_done;
  logic [CW-1:0] eff_ref, eff_win;
  logic [15:0]   smp_abs;
  logic [SW-1:0] sum_abs;
  logic signed [16:0] dlt;
  logic [16:0]   dlt_abs;
  logic [W-1:0]  n_w;

  function automatic logic [CW-1:0] eff_len(input logic [11:0] v);
    logic [CW-1:0] n;
    n = (v == '0) ? CW'(1) : CW'(v);
    if (n > CW'(MAX_WINDOW)) n = CW'(MAX_WINDOW);
    return n;
  endfunction

  assign smp_in[0] = in_chan.accel_x;
  assign smp_in[1] = in_chan.accel_y;
  assign smp_in[2] = in_chan.accel_z;

  assign in_chan.ready = (st_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cfg_wr        = psel && penable && pwrite;
  assign pready        = 1'b1;
  assign eff_ref       = eff_len(ref_r);
  assign eff_win       = eff_len(win_r);
  assign n_w           = W'(cnt_r);

  // magnitudes feeding the shared unit
  assign smp_abs = smp_r[k_r][15] ? (~smp_r[k_r] + 1'b1) : smp_r[k_r];
  assign sum_abs = sum_r[k_r][SW-1] ? (~sum_r[k_r] + 1'b1) : sum_r[k_r];
  assign dlt     = 17'(mean_r[k_r]) - 17'(last_r[k_r]);
  assign dlt_abs = dlt[16] ? (~dlt + 1'b1) : dlt;

  always_comb begin
    op_state = 1'b1;
    cmd.op   = OP_MUL;
    u_a      = '0;
    u_b      = '0;
    unique case (st_r)
      S_SQ: begin
        u_a = W'(smp_abs);
        u_b = W'(smp_abs);
      end
      S_NSQ: begin
        u_a = n_w;
        u_b = W'(sq_r[k_r]);
      end
      S_SS: begin
        u_a = W'(sum_abs);
        u_b = W'(sum_abs);
      end
      S_N2: begin
        u_a = n_w;
        u_b = n_w;
      end
      S_VDIV: begin
        cmd.op = OP_DIV;
        u_a    = {num_r[W-9:0], 8'd0};
        u_b    = tmp_r;
      end
      S_MDIV: begin
        cmd.op = OP_DIV;
        u_a    = W'(sum_abs);
        u_b    = n_w;
      end
      S_DSQ: begin
        u_a = W'(dlt_abs);
        u_b = W'(dlt_abs);
      end
      S_ND2: begin
        u_a = n_w;
        u_b = W'(d2_r);
      end
      S_P1: begin
        u_a = W'(stab_r);
        u_b = W'(refvar_r);
      end
      S_P2: begin
        u_a = W'(dev_r);
        u_b = W'(refvar_r);
      end
      S_IDLE, S_CHK, S_OUT: op_state = 1'b0;
      default: op_state = 1'b0;
    endcase
    cmd.start = op_state && !busy_wait_r && !sts.busy;
  end

  assign unit_done = op_state && busy_wait_r && sts.done;

  spar_muldiv #(.W(W)) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .a     (u_a),
    .b     (u_b),
    .sts   (sts),
    .res   (u_res)
  );

  always_comb begin
    st_nxt        = st_r;
    busy_wait_nxt = busy_wait_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    last_nxt      = last_r;
    mean_nxt      = mean_r;
    refvar_nxt    = refvar_r;
    var_nxt       = var_r;
    num_nxt       = num_r;
    tmp_nxt       = tmp_r;
    p1_nxt        = p1_r;
    d2_nxt        = d2_r;
    ok_nxt        = ok_r;
    ov_nxt        = ov_r;
    om_nxt        = om_r;
    ovar_nxt      = ovar_r;
    oacc_nxt      = oacc_r;

    if (ov_r && out_chan.ready) ov_nxt = 1'b0;
    if (cmd.start) busy_wait_nxt = 1'b1;
    if (unit_done) busy_wait_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          if (phase_r == PH_WAIT && cnt_r < CW'(wait_r)) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            if (phase_r == PH_WAIT) begin
              phase_nxt = PH_REF;
              cnt_nxt   = '0;
              for (int i = 0; i < AXES; i++) begin
                sum_nxt[i] = '0;
                sq_nxt[i]  = '0;
              end
            end
            k_nxt  = '0;
            st_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        if (unit_done) begin
          sum_nxt[k_r] = sum_r[k_r] + SW'(smp_r[k_r]);
          sq_nxt[k_r]  = sq_r[k_r] + QW'(u_res);
          if (k_r == K_LAST) begin
            cnt_nxt = cnt_r + 1'b1;
            st_nxt  = S_CHK;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_CHK: begin
        k_nxt   = '0;
        num_nxt = '0;
        if (cnt_r >= ((phase_r == PH_REF) ? eff_ref : eff_win)) begin
          st_nxt = S_NSQ;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_NSQ: begin
        if (unit_done) begin
          tmp_nxt = u_res;
          st_nxt  = S_SS;
        end
      end
      S_SS: begin
        if (unit_done) begin
          if (tmp_r > u_res) num_nxt = num_r + (tmp_r - u_res);
          if (k_r == K_LAST) begin
            st_nxt = S_N2;
          end else begin
            k_nxt  = k_r + 1'b1;
            st_nxt = S_NSQ;
          end
        end
      end
      S_N2: begin
        if (unit_done) begin
          tmp_nxt = u_res;
          st_nxt  = S_VDIV;
        end
      end
      S_VDIV: begin
        if (unit_done) begin
          var_nxt = (u_res > W'(VAR_MAX)) ? VAR_MAX : u_res[VAR_W-1:0];
          if (phase_r == PH_REF) begin
            refvar_nxt = var_nxt;
            phase_nxt  = PH_REC;
            cnt_nxt    = '0;
            for (int i = 0; i < AXES; i++) begin
              sum_nxt[i] = '0;
              sq_nxt[i]  = '0;
            end
            st_nxt = S_IDLE;
          end else begin
            k_nxt  = '0;
            d2_nxt = '0;
            st_nxt = S_MDIV;
          end
        end
      end
      S_MDIV: begin
        if (unit_done) begin
          // truncate toward zero: divide the magnitude, then restore the sign
          mean_nxt[k_r] = sum_r[k_r][SW-1] ? (~u_res[15:0] + 1'b1) : u_res[15:0];
          st_nxt        = S_DSQ;
        end
      end
      S_DSQ: begin
        if (unit_done) begin
          d2_nxt = d2_r + 36'(u_res);
          if (k_r == K_LAST) begin
            st_nxt = S_ND2;
          end else begin
            k_nxt  = k_r + 1'b1;
            st_nxt = S_MDIV;
          end
        end
      end
      S_ND2: begin
        if (unit_done) begin
          tmp_nxt = u_res;
          st_nxt  = S_P1;
        end
      end
      S_P1: begin
        if (unit_done) begin
          p1_nxt = u_res;
          st_nxt = S_P2;
        end
      end
      S_P2: begin
        if (unit_done) begin
          ok_nxt = (p1_r > {var_r, 8'd0}) && ({tmp_r[W-17:0], 16'd0} > u_res);
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_chan.ready) begin
          ov_nxt = 1'b1;
          // unused axes read as zero
          for (int i = 0; i < 3; i++) om_nxt[i] = 16'sd0;
          for (int i = 0; i < AXES; i++) om_nxt[i] = mean_r[i];
          ovar_nxt = var_r;
          oacc_nxt = ok_r;
          if (ok_r) last_nxt = mean_r;
          cnt_nxt = '0;
          for (int i = 0; i < AXES; i++) begin
            sum_nxt[i] = '0;
            sq_nxt[i]  = '0;
          end
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      busy_wait_r <= 1'b0;
      phase_r     <= PH_WAIT;
      cnt_r       <= '0;
      refvar_r    <= '0;
      ov_r        <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        sum_r[i]  <= '0;
        sq_r[i]   <= '0;
        last_r[i] <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      busy_wait_r <= busy_wait_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      refvar_r    <= refvar_nxt;
      ov_r        <= ov_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      last_r      <= last_nxt;
    end
    k_r    <= k_nxt;
    mean_r <= mean_nxt;
    var_r  <= var_nxt;
    num_r  <= num_nxt;
    tmp_r  <= tmp_nxt;
    p1_r   <= p1_nxt;
    d2_r   <= d2_nxt;
    ok_r   <= ok_nxt;
    om_r   <= om_nxt;
    ovar_r <= ovar_nxt;
    oacc_r <= oacc_nxt;
    if (in_fire) begin
      for (int i = 0; i < AXES; i++) smp_r[i] <= smp_in[i];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= WAIT_RST;
      ref_r  <= REF_RST;
      win_r  <= WIN_RST;
      stab_r <= STAB_RST;
      dev_r  <= DEV_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_WAIT: wait_r <= pwdata[11:0];
        REG_REF:  ref_r  <= pwdata[11:0];
        REG_WIN:  win_r  <= pwdata[11:0];
        REG_STAB: stab_r <= pwdata[15:0];
        REG_DEV:  dev_r  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WAIT: prdata = CFG_DW'(wait_r);
      REG_REF:  prdata = CFG_DW'(ref_r);
      REG_WIN:  prdata = CFG_DW'(win_r);
      REG_STAB: prdata = CFG_DW'(stab_r);
      REG_DEV:  prdata = CFG_DW'(dev_r);
      default:  prdata = '0;
    endcase
  end

  assign out_chan.valid           = ov_r;
  assign out_chan.mean_x          = om_r[0];
  assign out_chan.mean_y          = om_r[1];
  assign out_chan.mean_z          = om_r[2];
  assign out_chan.window_variance = ovar_r;
  assign out_chan.accepted        = oacc_r;

endmodule
